/* design/sftr_pkg.sv */
`default_nettype none
package sftr_pkg;

   // Configuration port geometry.
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // Register field widths.
   localparam int COORD_W = 11;
   localparam int SCALE_W = 4;
   localparam int COLOR_W = 16;

   // Result field widths.
   localparam int ROW_Y_W  = 12;
   localparam int CURSOR_W = 16;
   localparam int MASK_W   = 48;

   // Font storage: seven rows of five bits per glyph.
   localparam int ROM_ROWS   = 7;
   localparam int GLYPH_BITS = 5;

   // Character codes used for case folding.
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // Register reset values.
   localparam logic [COORD_W-1:0] ORIGIN_X_RESET  = 11'd0;
   localparam logic [COORD_W-1:0] ORIGIN_Y_RESET  = 11'd0;
   localparam logic [SCALE_W-1:0] SCALE_RESET     = 4'd1;
   localparam logic [COORD_W-1:0] FB_WIDTH_RESET  = 11'd320;
   localparam logic [COORD_W-1:0] FB_HEIGHT_RESET = 11'd240;
   localparam logic [COLOR_W-1:0] FG_COLOR_RESET  = 16'hFFFF;
   localparam logic [COLOR_W-1:0] BG_COLOR_RESET  = 16'h0000;

   typedef enum logic [2:0] {
      REG_ORIGIN_X  = 3'd0,
      REG_ORIGIN_Y  = 3'd1,
      REG_SCALE     = 3'd2,
      REG_FB_WIDTH  = 3'd3,
      REG_FB_HEIGHT = 3'd4,
      REG_FG_COLOR  = 3'd5,
      REG_BG_COLOR  = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] origin_x;
      logic [COORD_W-1:0] origin_y;
      logic [SCALE_W-1:0] scale;
      logic [COORD_W-1:0] fb_width;
      logic [COORD_W-1:0] fb_height;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic setup;
      logic build_mask;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic last_row;
   } dp_status_type;

   typedef logic [0:ROM_ROWS-1][GLYPH_BITS-1:0] glyph_type;

   // Folds lower case to upper case and returns the glyph bitmap, top row first.
   // The leftmost column is the most significant bit. Unknown codes are blank.
   function automatic glyph_type char_glyph(input logic [7:0] code);
      logic [7:0] c;
      glyph_type  g;
      c = code;
      if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
         c = code - CASE_OFFSET;
      end
      case (c)
         8'h2D: g = '{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00}; // '-'
         8'h3A: g = '{5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00}; // ':'
         8'h30: g = '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E}; // '0'
         8'h31: g = '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E}; // '1'
         8'h32: g = '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F}; // '2'
         8'h33: g = '{5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E}; // '3'
         8'h34: g = '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02}; // '4'
         8'h35: g = '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E}; // '5'
         8'h36: g = '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E}; // '6'
         8'h37: g = '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08}; // '7'
         8'h38: g = '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E}; // '8'
         8'h39: g = '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C}; // '9'
         8'h41: g = '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}; // 'A'
         8'h43: g = '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E}; // 'C'
         8'h44: g = '{5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C}; // 'D'
         8'h45: g = '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F}; // 'E'
         8'h46: g = '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10}; // 'F'
         8'h47: g = '{5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F}; // 'G'
         8'h49: g = '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E}; // 'I'
         8'h4C: g = '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F}; // 'L'
         8'h50: g = '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10}; // 'P'
         8'h52: g = '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11}; // 'R'
         8'h53: g = '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E}; // 'S'
         8'h54: g = '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}; // 'T'
         8'h56: g = '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04}; // 'V'
         8'h57: g = '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11}; // 'W'
         default: g = '0; // Space and every code without a glyph.
      endcase
      return g;
   endfunction

endpackage
`default_nettype wire

/* design/sftr_csr.sv */
`default_nettype none
module sftr_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sftr_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [sftr_pkg::DATA_W-1:0] csr_pwdata,
   output logic [sftr_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready,
   output sftr_pkg::cfg_type           cfg
);
   import sftr_pkg::*;

   logic [COORD_W-1:0] origin_x_ff;
   logic [COORD_W-1:0] origin_y_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic [COORD_W-1:0] fb_width_ff;
   logic [COORD_W-1:0] fb_height_ff;
   logic [COLOR_W-1:0] fg_color_ff;
   logic [COLOR_W-1:0] bg_color_ff;

   reg_index_type reg_index;
   logic          wr_en;

   assign reg_index  = reg_index_type'(csr_paddr[ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= ORIGIN_X_RESET;
         origin_y_ff  <= ORIGIN_Y_RESET;
         scale_ff     <= SCALE_RESET;
         fb_width_ff  <= FB_WIDTH_RESET;
         fb_height_ff <= FB_HEIGHT_RESET;
         fg_color_ff  <= FG_COLOR_RESET;
         bg_color_ff  <= BG_COLOR_RESET;
      end else if (wr_en) begin
         unique case (reg_index)
            REG_ORIGIN_X:  origin_x_ff  <= csr_pwdata[COORD_W-1:0];
            REG_ORIGIN_Y:  origin_y_ff  <= csr_pwdata[COORD_W-1:0];
            REG_SCALE:     scale_ff     <= csr_pwdata[SCALE_W-1:0];
            REG_FB_WIDTH:  fb_width_ff  <= csr_pwdata[COORD_W-1:0];
            REG_FB_HEIGHT: fb_height_ff <= csr_pwdata[COORD_W-1:0];
            REG_FG_COLOR:  fg_color_ff  <= csr_pwdata[COLOR_W-1:0];
            REG_BG_COLOR:  bg_color_ff  <= csr_pwdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_ORIGIN_X:  csr_prdata = DATA_W'(origin_x_ff);
         REG_ORIGIN_Y:  csr_prdata = DATA_W'(origin_y_ff);
         REG_SCALE:     csr_prdata = DATA_W'(scale_ff);
         REG_FB_WIDTH:  csr_prdata = DATA_W'(fb_width_ff);
         REG_FB_HEIGHT: csr_prdata = DATA_W'(fb_height_ff);
         REG_FG_COLOR:  csr_prdata = DATA_W'(fg_color_ff);
         REG_BG_COLOR:  csr_prdata = DATA_W'(bg_color_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.origin_x  = origin_x_ff;
   assign cfg.origin_y  = origin_y_ff;
   assign cfg.scale     = scale_ff;
   assign cfg.fb_width  = fb_width_ff;
   assign cfg.fb_height = fb_height_ff;

endmodule
`default_nettype wire

/* design/sftr_ctrl.sv */
`default_nettype none
module sftr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  sftr_pkg::dp_status_type status,
   output sftr_pkg::ctrl_cmd_type  cmd
);
   import sftr_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SETUP = 4'b0010,
      ST_MASK  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_stall      = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_MASK;
         end
         ST_MASK: begin
            cmd.build_mask = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            // A row moves into the output register whenever it is empty or being taken.
            cmd.emit = status.out_free;
            if (status.out_free && status.last_row) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* design/sftr_dp.sv */
`default_nettype none
module sftr_dp #(
   parameter int GLYPH_WIDTH  = 5,
   parameter int GLYPH_HEIGHT = 7,
   parameter int MAX_SCALE    = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sftr_pkg::cfg_type                    cfg,
   input  sftr_pkg::ctrl_cmd_type               cmd,
   output sftr_pkg::dp_status_type              status,
   input  logic [7:0]                           req_char_code,
   input  logic                                 req_restart,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [sftr_pkg::ROW_Y_W-1:0]  rsp_row_y,
   output logic signed [sftr_pkg::CURSOR_W-1:0] rsp_x_start,
   output logic [sftr_pkg::MASK_W-1:0]          rsp_pixel_mask,
   output logic [sftr_pkg::MASK_W-1:0]          rsp_write_mask,
   output logic signed [sftr_pkg::CURSOR_W-1:0] rsp_next_cursor,
   output logic                                 rsp_last_row
);
   import sftr_pkg::*;

   localparam int S_W    = $clog2(MAX_SCALE + 1);
   localparam int CW_W   = $clog2((GLYPH_WIDTH + 1) * MAX_SCALE + 1);
   localparam int GR_W   = $clog2(GLYPH_HEIGHT);
   localparam int EDGE_W = CURSOR_W + 2;
   localparam logic [SCALE_W-1:0] MAX_S = SCALE_W'(MAX_SCALE);

   // Character state.
   logic [CURSOR_W-1:0]      cursor_ff;
   logic [CURSOR_W-1:0]      x0_ff;
   glyph_type                glyph_ff;
   logic [S_W-1:0]           s_ff;
   logic [CW_W-1:0]          cell_w_ff;
   logic [CURSOR_W-1:0]      next_ff;
   logic signed [EDGE_W-1:0] lo_ff;
   logic signed [EDGE_W-1:0] hi_ff;
   logic [MASK_W-1:0]        colmask_ff;

   // Row walk.
   logic [ROW_Y_W-1:0] y_ff;
   logic [S_W-1:0]     sub_ff;
   logic [GR_W-1:0]    gr_ff;

   // Output register.
   logic                rsp_valid_ff;
   logic [ROW_Y_W-1:0]  row_y_ff;
   logic [CURSOR_W-1:0] x_start_ff;
   logic [MASK_W-1:0]   pixel_mask_ff;
   logic [MASK_W-1:0]   write_mask_ff;
   logic [CURSOR_W-1:0] next_cursor_ff;
   logic                last_row_ff;

   logic [SCALE_W-1:0]       s_eff;
   logic [CW_W-1:0]          cell_w;
   logic [CURSOR_W:0]        next_sum;
   logic [CURSOR_W-1:0]      next_sat;
   logic signed [EDGE_W-1:0] x0_ext;
   logic [GLYPH_BITS-1:0]    row_bits;
   logic [MASK_W-1:0]        scaled_row [1:MAX_SCALE];
   logic                     sub_last;
   logic                     row_last;
   logic                     row_in;
   logic [MASK_W-1:0]        colmask_in;

   // Scale 0 acts as 1, anything above the maximum acts as the maximum.
   always_comb begin
      if (cfg.scale == '0) begin
         s_eff = SCALE_W'(1);
      end else if (cfg.scale > MAX_S) begin
         s_eff = MAX_S;
      end else begin
         s_eff = cfg.scale;
      end
   end

   assign cell_w   = CW_W'(s_ff) * CW_W'(GLYPH_WIDTH + 1);
   assign next_sum = {x0_ff[CURSOR_W-1], x0_ff} + (CURSOR_W + 1)'(cell_w);
   // The cell width is positive, so only the upper limit can be crossed.
   assign next_sat = (!next_sum[CURSOR_W] && next_sum[CURSOR_W-1]) ?
                     {1'b0, {(CURSOR_W - 1){1'b1}}} : next_sum[CURSOR_W-1:0];
   assign x0_ext   = $signed({{2{x0_ff[CURSOR_W-1]}}, x0_ff});

   // Cell columns i with 0 <= x0 + i < fb_width and i inside the cell.
   always_comb begin
      for (int i = 0; i < MASK_W; i++) begin
         colmask_in[i] = ($signed(EDGE_W'(i)) >= lo_ff) && ($signed(EDGE_W'(i)) < hi_ff) &&
                         (i < int'(cell_w_ff));
      end
   end

   always_comb begin
      row_bits = '0;
      if (int'(gr_ff) < ROM_ROWS) begin
         row_bits = glyph_ff[3'(gr_ff)];
      end
   end

   // One expanded row per scale; each mask bit picks its glyph column.
   for (genvar k = 1; k <= MAX_SCALE; k++) begin : g_scale
      for (genvar i = 0; i < MASK_W; i++) begin : g_bit
         localparam int COL = i / k;
         localparam int BIT = GLYPH_WIDTH - 1 - COL;
         if (COL < GLYPH_WIDTH && BIT < GLYPH_BITS) begin : g_on
            assign scaled_row[k][i] = row_bits[BIT];
         end else begin : g_off
            assign scaled_row[k][i] = 1'b0;
         end
      end
   end

   assign sub_last = (sub_ff == S_W'(s_ff - 1'b1));
   assign row_last = sub_last && (gr_ff == GR_W'(GLYPH_HEIGHT - 1));
   assign row_in   = !y_ff[ROW_Y_W-1] && (y_ff[COORD_W-1:0] < cfg.fb_height);

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign status.last_row = row_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
      end else if (cmd.setup) begin
         cursor_ff <= next_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         x0_ff    <= req_restart ? {{(CURSOR_W - COORD_W){cfg.origin_x[COORD_W-1]}}, cfg.origin_x}
                                 : cursor_ff;
         glyph_ff <= char_glyph(req_char_code);
         s_ff     <= S_W'(s_eff);
         y_ff     <= {cfg.origin_y[COORD_W-1], cfg.origin_y};
      end
      if (cmd.setup) begin
         cell_w_ff <= cell_w;
         next_ff   <= next_sat;
         lo_ff     <= -x0_ext;
         hi_ff     <= $signed({{(EDGE_W - COORD_W){1'b0}}, cfg.fb_width}) - x0_ext;
         sub_ff    <= '0;
         gr_ff     <= '0;
      end
      if (cmd.build_mask) begin
         colmask_ff <= colmask_in;
      end
      if (cmd.emit) begin
         y_ff <= y_ff + 1'b1;
         if (sub_last) begin
            sub_ff <= '0;
            gr_ff  <= gr_ff + 1'b1;
         end else begin
            sub_ff <= sub_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         row_y_ff       <= y_ff;
         x_start_ff     <= x0_ff;
         pixel_mask_ff  <= scaled_row[s_ff];
         write_mask_ff  <= colmask_ff & {MASK_W{row_in}};
         next_cursor_ff <= next_ff;
         last_row_ff    <= row_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_y       = $signed(row_y_ff);
   assign rsp_x_start     = $signed(x_start_ff);
   assign rsp_pixel_mask  = pixel_mask_ff;
   assign rsp_write_mask  = write_mask_ff;
   assign rsp_next_cursor = $signed(next_cursor_ff);
   assign rsp_last_row    = last_row_ff;

endmodule
`default_nettype wire

/* design/scaled_font_text_renderer_unit.sv */
`default_nettype none
// Text renderer for a 5x7 bitmap font. Each item is one character byte (lower case
// is drawn as upper case, codes without a glyph draw blank) plus a restart flag that
// moves the cursor back to origin_x first. For every scaled row of the character cell,
// top to bottom, one item leaves with the row's y, the cell's left x, a foreground mask
// and a write mask clipped to the framebuffer; the pixel writes themselves belong to a
// downstream writer. A character is taken in the idle state, its cell geometry and
// clipping window are set up in the setup and mask states, then the row generator
// gives one row per cycle while the result side does not stall. One character is in
// work at a time; the next is taken as soon as its last row sits in the output
// register. The cursor advances by (GLYPH_WIDTH+1)*scale per character and
// saturates at 32767. Registers are at byte addresses 0 to 24 in steps
// of 4: origin_x, origin_y, scale, fb_width, fb_height, fg_color, bg_color; write them
// only while no character is in work.
module scaled_font_text_renderer_unit #(
   parameter int GLYPH_WIDTH  = 5,
   parameter int GLYPH_HEIGHT = 7,
   parameter int MAX_SCALE    = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [sftr_pkg::ADDR_W-1:0]          csr_paddr,
   input  logic [sftr_pkg::DATA_W-1:0]          csr_pwdata,
   output logic [sftr_pkg::DATA_W-1:0]          csr_prdata,
   output logic                                 csr_pready,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_char_code,
   input  logic                                 req_restart,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [sftr_pkg::ROW_Y_W-1:0]  rsp_row_y,
   output logic signed [sftr_pkg::CURSOR_W-1:0] rsp_x_start,
   output logic [sftr_pkg::MASK_W-1:0]          rsp_pixel_mask,
   output logic [sftr_pkg::MASK_W-1:0]          rsp_write_mask,
   output logic signed [sftr_pkg::CURSOR_W-1:0] rsp_next_cursor,
   output logic                                 rsp_last_row
);
   import sftr_pkg::*;

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   sftr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sftr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sftr_dp #(
      .GLYPH_WIDTH  (GLYPH_WIDTH),
      .GLYPH_HEIGHT (GLYPH_HEIGHT),
      .MAX_SCALE    (MAX_SCALE)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .status          (status),
      .req_char_code   (req_char_code),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_row_y       (rsp_row_y),
      .rsp_x_start     (rsp_x_start),
      .rsp_pixel_mask  (rsp_pixel_mask),
      .rsp_write_mask  (rsp_write_mask),
      .rsp_next_cursor (rsp_next_cursor),
      .rsp_last_row    (rsp_last_row)
   );

endmodule
`default_nettype wire

/* tb/tb_scaled_font_text_renderer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_scaled_font_text_renderer_unit;
   import sftr_pkg::*;

   localparam int FONT_W    = 5;
   localparam int FONT_H    = 7;
   localparam int SCALE_MAX = 8;
   localparam int CURSOR_MAX = 32767;

   typedef struct {
      logic [7:0] code;
      logic       restart;
   } char_item_type;

   typedef struct {
      logic signed [ROW_Y_W-1:0]  row_y;
      logic signed [CURSOR_W-1:0] x_start;
      logic [MASK_W-1:0]          pixel_mask;
      logic [MASK_W-1:0]          write_mask;
      logic signed [CURSOR_W-1:0] next_cursor;
      logic                       last_row;
   } row_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 csr_psel    = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0]    csr_paddr   = '0;
   logic [DATA_W-1:0]    csr_pwdata  = '0;
   logic [DATA_W-1:0]    csr_prdata;
   logic                 csr_pready;

   logic                 req_valid     = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_char_code = 8'h00;
   logic                 req_restart   = 1'b0;

   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [ROW_Y_W-1:0]  rsp_row_y;
   logic signed [CURSOR_W-1:0] rsp_x_start;
   logic [MASK_W-1:0]          rsp_pixel_mask;
   logic [MASK_W-1:0]          rsp_write_mask;
   logic signed [CURSOR_W-1:0] rsp_next_cursor;
   logic                       rsp_last_row;

   // Shadow copy of the origin, scale and framebuffer registers and the text cursor.
   logic signed [COORD_W-1:0] origin_x_cfg  = ORIGIN_X_RESET;
   logic signed [COORD_W-1:0] origin_y_cfg  = ORIGIN_Y_RESET;
   logic [SCALE_W-1:0]        scale_cfg     = SCALE_RESET;
   logic [COORD_W-1:0]        fb_width_cfg  = FB_WIDTH_RESET;
   logic [COORD_W-1:0]        fb_height_cfg = FB_HEIGHT_RESET;
   int                        cursor_x      = 0;

   char_item_type  pending_chars[$];
   row_result_type pending_rows[$];
   int          fail_count    = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   string       font_chars    = " -:0123456789ACDEFGILPRSTVW";

   scaled_font_text_renderer_unit dut (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_row_y       (rsp_row_y),
      .rsp_x_start     (rsp_x_start),
      .rsp_pixel_mask  (rsp_pixel_mask),
      .rsp_write_mask  (rsp_write_mask),
      .rsp_next_cursor (rsp_next_cursor),
      .rsp_last_row    (rsp_last_row)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Seven rows of five bits, top row in the most significant bits.
   function automatic logic [34:0] glyph_bitmap(input logic [7:0] code);
      logic [7:0]  c;
      logic [34:0] bm;
      c = code;
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         c = c - CASE_OFFSET;
      end
      case (c)
         "-": bm = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
         ":": bm = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
         "0": bm = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
         "1": bm = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
         "2": bm = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
         "3": bm = {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
         "4": bm = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
         "5": bm = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
         "6": bm = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
         "7": bm = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
         "8": bm = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
         "9": bm = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
         "A": bm = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
         "C": bm = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
         "D": bm = {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
         "E": bm = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
         "F": bm = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
         "G": bm = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
         "I": bm = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
         "L": bm = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
         "P": bm = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
         "R": bm = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
         "S": bm = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
         "T": bm = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
         "V": bm = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
         "W": bm = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
         default: bm = '0;
      endcase
      return bm;
   endfunction

   // Works out every scaled row of one character and moves the cursor on.
   task automatic render_char(input logic [7:0] code, input logic restart);
      int             s, cell_w, rows, x0, y0, nxt, y, gr, col, fbw, fbh;
      logic [34:0]    bm;
      logic [4:0]     bits;
      logic           row_in;
      row_result_type rr;
      s = scale_cfg;
      if (s < 1) begin
         s = 1;
      end
      if (s > SCALE_MAX) begin
         s = SCALE_MAX;
      end
      if (restart) begin
         cursor_x = origin_x_cfg;
      end
      bm     = glyph_bitmap(code);
      cell_w = (FONT_W + 1) * s;
      rows   = FONT_H * s;
      x0     = cursor_x;
      y0     = origin_y_cfg;
      fbw    = fb_width_cfg;
      fbh    = fb_height_cfg;
      nxt    = x0 + cell_w;
      if (nxt > CURSOR_MAX) begin
         nxt = CURSOR_MAX;
      end
      for (int r = 0; r < rows; r++) begin
         y      = y0 + r;
         gr     = r / s;
         bits   = (gr < FONT_H) ? bm[34 - 5 * gr -: 5] : 5'h00;
         row_in = (y >= 0) && (y < fbh);
         rr.pixel_mask = '0;
         rr.write_mask = '0;
         for (int i = 0; i < cell_w && i < MASK_W; i++) begin
            col = i / s;
            if (col < FONT_W && bits[FONT_W - 1 - col]) begin
               rr.pixel_mask[i] = 1'b1;
            end
            if (row_in && x0 + i >= 0 && x0 + i < fbw) begin
               rr.write_mask[i] = 1'b1;
            end
         end
         rr.row_y       = y[ROW_Y_W-1:0];
         rr.x_start     = x0[CURSOR_W-1:0];
         rr.next_cursor = nxt[CURSOR_W-1:0];
         rr.last_row    = (r == rows - 1);
         pending_rows.push_back(rr);
      end
      cursor_x = nxt;
   endtask

   always @(posedge clock) begin : char_driver
      char_item_type nxt_char;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            render_char(req_char_code, req_restart);
         end
         if (!req_valid || !req_stall) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt_char = pending_chars.pop_front();
               req_valid     <= 1'b1;
               req_char_code <= nxt_char.code;
               req_restart   <= nxt_char.restart;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : row_monitor
      row_result_type got, want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_row_y, rsp_x_start, rsp_pixel_mask, rsp_write_mask,
                    rsp_next_cursor, rsp_last_row};
            if (pending_rows.size() == 0) begin
               if (fail_count < 10) begin
                  $display("Unexpected row: y %0d x %0d pix %h wr %h next %0d last %0b",
                           got.row_y, got.x_start, got.pixel_mask, got.write_mask,
                           got.next_cursor, got.last_row);
               end
               fail_count++;
            end else begin
               want = pending_rows.pop_front();
               if (got.row_y !== want.row_y || got.x_start !== want.x_start ||
                   got.pixel_mask !== want.pixel_mask ||
                   got.write_mask !== want.write_mask ||
                   got.next_cursor !== want.next_cursor ||
                   got.last_row !== want.last_row) begin
                  if (fail_count < 10) begin
                     $display("Row mismatch at %0t", $realtime);
                     $display("  exp y %0d x %0d pix %h wr %h next %0d last %0b",
                              want.row_y, want.x_start, want.pixel_mask,
                              want.write_mask, want.next_cursor, want.last_row);
                     $display("  got y %0d x %0d pix %h wr %h next %0d last %0b",
                              got.row_y, got.x_start, got.pixel_mask,
                              got.write_mask, got.next_cursor, got.last_row);
                  end
                  fail_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic write_reg(input reg_index_type idx, input logic [DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_ORIGIN_X:  origin_x_cfg  = value[COORD_W-1:0];
         REG_ORIGIN_Y:  origin_y_cfg  = value[COORD_W-1:0];
         REG_SCALE:     scale_cfg     = value[SCALE_W-1:0];
         REG_FB_WIDTH:  fb_width_cfg  = value[COORD_W-1:0];
         REG_FB_HEIGHT: fb_height_cfg = value[COORD_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int ox, input int oy, input int sc, input int fw,
                             input int fh, input int fg, input int bg);
      write_reg(REG_ORIGIN_X, ox);
      write_reg(REG_ORIGIN_Y, oy);
      write_reg(REG_SCALE, sc);
      write_reg(REG_FB_WIDTH, fw);
      write_reg(REG_FB_HEIGHT, fh);
      write_reg(REG_FG_COLOR, fg);
      write_reg(REG_BG_COLOR, bg);
   endtask

   // Origins near zero and small framebuffers make partial clipping common.
   task automatic randomize_config();
      int ox, oy, sc, fw, fh;
      ox = $urandom_range(0, 120);
      ox = $urandom_range(1) ? int'($urandom_range(0, 2047)) : ox - 60;
      oy = $urandom_range(0, 100);
      oy = $urandom_range(1) ? int'($urandom_range(0, 2047)) : oy - 50;
      sc = $urandom_range(1) ? $urandom_range(0, 15) : $urandom_range(1, 3);
      fw = $urandom_range(1) ? $urandom_range(0, 2047) : $urandom_range(0, 200);
      fh = $urandom_range(1) ? $urandom_range(0, 2047) : $urandom_range(0, 60);
      set_config(ox, oy, sc, fw, fh, $urandom_range(0, 65535), $urandom_range(0, 65535));
   endtask

   task automatic queue_char(input logic [7:0] code, input logic restart);
      char_item_type item;
      item.code    = code;
      item.restart = restart;
      pending_chars.push_back(item);
   endtask

   // Mostly characters that have a glyph, in either case, with some raw bytes.
   function automatic logic [7:0] pick_char();
      logic [7:0] c;
      if ($urandom_range(9) < 3) begin
         c = $urandom_range(0, 255);
      end else begin
         c = font_chars[$urandom_range(0, font_chars.len() - 1)];
         if (c >= "A" && c <= "Z" && $urandom_range(1)) begin
            c = c + CASE_OFFSET;
         end
      end
      return c;
   endfunction

   task automatic queue_random_text(input int count);
      for (int n = 0; n < count; n++) begin
         queue_char(pick_char(), $urandom_range(9) == 0);
      end
   endtask

   task automatic wait_until_drained();
      do begin
         @(negedge clock);
      end while (pending_chars.size() != 0 || req_valid || pending_rows.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 61 : 0;
         recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 26 : 0;
         if (phase == 0) begin
            // Zero scale and an empty framebuffer at the most negative origin.
            set_config(-1024, -1024, 0, 0, 0, 16'h0000, 16'hFFFF);
            queue_char("A", 1'b1);
            queue_char(8'h00, 1'b0);
            queue_char("w", 1'b0);
            wait_until_drained();
            // Scale above the maximum and the largest coordinates.
            set_config(1023, 1023, 15, 2047, 2047, 16'hFFFF, 16'h0000);
            queue_char("W", 1'b1);
            queue_char(8'hFF, 1'b0);
            queue_char("8", 1'b0);
            wait_until_drained();
            // Cells straddle both framebuffer edges in x and in y.
            set_config(-10, -4, 2, 20, 6, 16'h1234, 16'h8421);
            queue_char(" ", 1'b1);
            queue_char("-", 1'b0);
            queue_char(":", 1'b0);
            queue_char("0", 1'b0);
            queue_char("9", 1'b0);
            queue_char("a", 1'b0);
            queue_char("z", 1'b0);
            queue_char(8'h60, 1'b0);
            queue_char(8'h7B, 1'b0);
            queue_char(8'h40, 1'b1);
            queue_char("g", 1'b0);
            queue_char("v", 1'b0);
            queue_char("Z", 1'b0);
            queue_char(8'h7F, 1'b1);
            wait_until_drained();
         end
         repeat (3) begin
            randomize_config();
            queue_random_text(38);
            wait_until_drained();
         end
      end

      // A short line at the largest scale, starting at the rightmost origin.
      set_config(1023, $urandom_range(0, 2047), SCALE_MAX, $urandom_range(0, 2047),
                 $urandom_range(0, 2047), $urandom_range(0, 65535), $urandom_range(0, 65535));
      queue_char(pick_char(), 1'b1);
      repeat (9) queue_char(pick_char(), 1'b0);
      wait_until_drained();

      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_rows.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
`default_nettype wire

/* filelist.f */
design/sftr_pkg.sv
design/sftr_csr.sv
design/sftr_ctrl.sv
design/sftr_dp.sv
design/scaled_font_text_renderer_unit.sv
tb/tb_scaled_font_text_renderer_unit.sv
